### rtl/core/eqts_pkg.sv
// Package for the event queue and timer scheduler.
// Holds sizes, operation and status codes, controller states and command types.
`default_nettype none
package eqts_pkg;

    localparam int NUM_TASKS   = 4;
    localparam int QUEUE_DEPTH = 8;
    localparam int NUM_TIMERS  = 8;

    localparam int TASK_W  = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOT_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int ADDR_W  = $clog2(NUM_TASKS * QUEUE_DEPTH);
    localparam int STORE_N = NUM_TASKS * QUEUE_DEPTH;

    typedef enum logic [2:0] {
        OP_POST     = 3'd0,
        OP_DISPATCH = 3'd1,
        OP_TICK     = 3'd2,
        OP_SET      = 3'd3,
        OP_RSET     = 3'd4,
        OP_DELETE   = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EXISTS    = 3'd2,
        ST_NO_TIMER  = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_IDLE      = 3'd5,
        ST_BAD_TASK  = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_RDWAIT,
        S_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input word
        logic exec;       // execute the op (post, dispatch read, task check)
        logic scan_step;  // process the current timer slot
        logic pop_done;   // finish dispatch once store data is back
        logic finish;     // present result
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_scan;    // op needs a timer scan
        logic is_pop;     // dispatch with a non-empty queue
        logic scan_end;   // scan is finished after this step
    } stat_t;

endpackage
`default_nettype wire

### rtl/core/event_queue_timer_scheduler_top.sv
// Event queue and timer scheduler, top level.
// One request word in on s_axis, one result word out on m_axis.
// Request tdata: operation[2:0], task_id[10:3], signal[18:11], amount[34:19].
// Result tdata: status[2:0], out_task[4:3], out_signal[12:5], event_valid[13].
// One request is processed at a time. Post, dispatch and bad-task or unused
// codes run without a slot walk; tick, set, reload-set and delete walk the
// timer slots one per cycle until the scan stops, after 1 to 8 slots; a tick
// of zero skips the walk. Dispatch waits for the registered store read
// before its result is presented. The next request is accepted in the cycle
// after the result is taken.
// The result sits in an output register; s_tready stays low until it has
// been taken, so a stalled receiver holds the block with the result intact.
// Reset (aresetn low, synchronous) empties all queues and frees all timers;
// queue memory contents are not cleared.
`default_nettype none
module event_queue_timer_scheduler_top
    import eqts_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // operation, task_id, signal, amount (from bit 0), zero pad
    input  wire logic [39:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status, out_task, out_signal, event_valid (from bit 0), zero pad
    output logic [15:0]      m_tdata
);

    cmd_t        cmd;
    stat_t       stat;
    logic        in_ready;
    logic        in_fire;
    logic        out_free;
    logic        m_valid_reg;
    logic [2:0]  res_status;
    logic [1:0]  res_task;
    logic [7:0]  res_signal;
    logic        res_valid;

    assign s_tready = in_ready && !m_valid_reg;
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    eqts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .out_free (out_free),
        .stat     (stat),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    eqts_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .in_op      (s_tdata[2:0]),
        .in_task    (s_tdata[10:3]),
        .in_signal  (s_tdata[18:11]),
        .in_amount  (s_tdata[34:19]),
        .stat       (stat),
        .res_status (res_status),
        .res_task   (res_task),
        .res_signal (res_signal),
        .res_valid  (res_valid)
    );

    // hold result word until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, res_valid, res_signal, res_task, res_status};

    // no new request while a result is pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !s_tready)
        else $error("request accepted with result pending");

    // event flag only with ok status
    a_valid_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[13]) |-> (m_tdata[2:0] == ST_OK))
        else $error("event with non-ok status");

    // result appears only after a finish command
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd.finish))
        else $error("result without finish");

endmodule
`default_nettype wire

### rtl/core/eqts_ctrl.sv
// Controller for the event queue and timer scheduler.
// Depends on eqts_pkg for states and command types.
`default_nettype none
module eqts_ctrl
    import eqts_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_fire,
    input  wire logic  out_free,
    input  wire stat_t stat,
    output logic       in_ready,
    output cmd_t       cmd
);

    state_t state_reg, state_next;

    // advance state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_fire) state_next = S_EXEC;
            end
            S_EXEC: begin
                if (stat.is_scan)     state_next = S_SCAN;
                else if (stat.is_pop) state_next = S_RDWAIT;
                else                  state_next = S_DONE;
            end
            S_SCAN: begin
                if (stat.scan_end) state_next = S_DONE;
            end
            S_RDWAIT: state_next = S_DONE;
            S_DONE: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_fire;
            end
            S_EXEC:   cmd.exec = 1'b1;
            S_SCAN:   cmd.scan_step = 1'b1;
            S_RDWAIT: cmd.pop_done = 1'b1;
            S_DONE:   cmd.finish = out_free;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

### rtl/core/eqts_datapath.sv
// Datapath: task queues, queue store memory, timer pool and result register.
// Depends on eqts_pkg; driven by eqts_ctrl commands.
`default_nettype none
module eqts_datapath
    import eqts_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire cmd_t        cmd,
    input  wire logic [2:0]  in_op,
    input  wire logic [7:0]  in_task,
    input  wire logic [7:0]  in_signal,
    input  wire logic [15:0] in_amount,
    output stat_t            stat,
    output logic [2:0]       res_status,
    output logic [1:0]       res_task,
    output logic [7:0]       res_signal,
    output logic             res_valid
);

    // captured request
    logic [2:0]  op_reg;
    logic [7:0]  task_reg;
    logic [7:0]  sig_reg;
    logic [15:0] amt_reg;

    // queue control
    logic [PTR_W-1:0] head_reg [NUM_TASKS];
    logic [PTR_W-1:0] tail_reg [NUM_TASKS];
    logic [CNT_W-1:0] count_reg [NUM_TASKS];

    // queue store, one write and one read port
    logic [7:0]        store_mem [STORE_N];
    logic [7:0]        rd_data_reg;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    // timer pool
    logic              t_active_reg [NUM_TIMERS];
    logic              t_repeat_reg [NUM_TIMERS];
    logic [TASK_W-1:0] t_owner_reg  [NUM_TIMERS];
    logic [7:0]        t_sig_reg    [NUM_TIMERS];
    logic [15:0]       t_rem_reg    [NUM_TIMERS];
    logic [15:0]       t_rel_reg    [NUM_TIMERS];
    logic [SLOT_W-1:0] slot_reg;

    logic [2:0]        status_reg;
    logic [TASK_W-1:0] otask_reg;
    logic              ovalid_reg;
    logic              done_reg;

    logic              task_ok;
    logic [TASK_W-1:0] tsk;
    logic              any_ne;
    logic [TASK_W-1:0] pop_t;
    logic              is_set;
    logic              slot_match;
    logic              slot_last;
    logic              expire;
    logic [TASK_W-1:0] own;

    assign task_ok = ({24'd0, task_reg} < NUM_TASKS);
    assign tsk     = task_reg[TASK_W-1:0];
    assign is_set  = (op_reg == OP_SET) || (op_reg == OP_RSET);

    // lowest non-empty queue
    always_comb begin
        any_ne = 1'b0;
        pop_t  = '0;
        for (int t = NUM_TASKS - 1; t >= 0; t--) begin
            if (count_reg[t] != '0) begin
                any_ne = 1'b1;
                pop_t  = TASK_W'(t);
            end
        end
    end

    // current slot terms
    assign own        = t_owner_reg[slot_reg];
    assign slot_match = t_active_reg[slot_reg] && ({24'd0, task_reg} == 32'(own))
                        && (t_sig_reg[slot_reg] == sig_reg);
    assign slot_last  = (32'(slot_reg) == NUM_TIMERS - 1);
    assign expire     = t_active_reg[slot_reg] && (t_rem_reg[slot_reg] <= amt_reg);

    // a tick of zero elapsed time skips the scan
    assign stat.is_scan = ((op_reg == OP_TICK) && (amt_reg != '0))
                        || (task_ok && (is_set || op_reg == OP_DELETE));
    assign stat.is_pop  = (op_reg == OP_DISPATCH) && any_ne;
    assign stat.scan_end = slot_last || done_reg
                        || (is_set && (slot_match || !t_active_reg[slot_reg]))
                        || ((op_reg == OP_DELETE) && slot_match);

    // store ports
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = sig_reg;
        rd_en   = cmd.exec && stat.is_pop;
        rd_addr = ADDR_W'(32'(pop_t) * QUEUE_DEPTH + 32'(head_reg[pop_t]));
        if (cmd.exec && op_reg == OP_POST && task_ok
            && 32'(count_reg[tsk]) < QUEUE_DEPTH) begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(32'(tsk) * QUEUE_DEPTH + 32'(tail_reg[tsk]));
        end
        if (cmd.scan_step && !done_reg && op_reg == OP_TICK && amt_reg != '0 && expire
            && 32'(count_reg[own]) < QUEUE_DEPTH) begin
            wr_en   = 1'b1;
            wr_data = t_sig_reg[slot_reg];
            wr_addr = ADDR_W'(32'(own) * QUEUE_DEPTH + 32'(tail_reg[own]));
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) store_mem[wr_addr] <= wr_data;
        if (rd_en) rd_data_reg <= store_mem[rd_addr];
    end

    // capture request
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= in_op;
            task_reg <= in_task;
            sig_reg  <= in_signal;
            amt_reg  <= in_amount;
        end
    end

    // queues, timers and result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int t = 0; t < NUM_TASKS; t++) begin
                head_reg[t]  <= '0;
                tail_reg[t]  <= '0;
                count_reg[t] <= '0;
            end
            for (int i = 0; i < NUM_TIMERS; i++) begin
                t_active_reg[i] <= 1'b0;
                t_repeat_reg[i] <= 1'b0;
            end
            slot_reg   <= '0;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
            otask_reg  <= '0;
            ovalid_reg <= 1'b0;
            res_status <= ST_OK;
            res_task   <= '0;
            res_signal <= '0;
            res_valid  <= 1'b0;
        end else begin
            if (cmd.load) begin
                slot_reg   <= '0;
                done_reg   <= 1'b0;
                status_reg <= ST_OK;
                otask_reg  <= '0;
                ovalid_reg <= 1'b0;
            end
            if (cmd.exec) begin
                case (op_reg)
                    OP_POST: begin
                        if (!task_ok) begin
                            status_reg <= ST_BAD_TASK;
                        end else if (32'(count_reg[tsk]) >= QUEUE_DEPTH) begin
                            status_reg <= ST_FULL;
                        end else begin
                            tail_reg[tsk]  <= (32'(tail_reg[tsk]) + 1 >= QUEUE_DEPTH)
                                              ? '0 : tail_reg[tsk] + 1'b1;
                            count_reg[tsk] <= count_reg[tsk] + 1'b1;
                        end
                    end
                    OP_DISPATCH: begin
                        if (any_ne) begin
                            head_reg[pop_t]  <= (32'(head_reg[pop_t]) + 1 >= QUEUE_DEPTH)
                                                ? '0 : head_reg[pop_t] + 1'b1;
                            count_reg[pop_t] <= count_reg[pop_t] - 1'b1;
                            otask_reg        <= pop_t;
                            ovalid_reg       <= 1'b1;
                        end else begin
                            status_reg <= ST_IDLE;
                        end
                    end
                    OP_SET, OP_RSET, OP_DELETE: begin
                        if (!task_ok) status_reg <= ST_BAD_TASK;
                    end
                    default: ;
                endcase
            end
            // one timer slot per cycle
            if (cmd.scan_step && !done_reg) begin
                slot_reg <= slot_reg + 1'b1;
                case (op_reg)
                    OP_TICK: begin
                        if (t_active_reg[slot_reg]) begin
                            if (!expire) begin
                                t_rem_reg[slot_reg] <= t_rem_reg[slot_reg] - amt_reg;
                            end else begin
                                if (32'(count_reg[own]) < QUEUE_DEPTH) begin
                                    tail_reg[own]  <= (32'(tail_reg[own]) + 1 >= QUEUE_DEPTH)
                                                      ? '0 : tail_reg[own] + 1'b1;
                                    count_reg[own] <= count_reg[own] + 1'b1;
                                end
                                if (t_repeat_reg[slot_reg])
                                    t_rem_reg[slot_reg] <= t_rel_reg[slot_reg];
                                else
                                    t_active_reg[slot_reg] <= 1'b0;
                            end
                        end
                    end
                    OP_SET, OP_RSET: begin
                        if (slot_match) begin
                            status_reg <= ST_EXISTS;
                            done_reg   <= 1'b1;
                        end else if (!t_active_reg[slot_reg]) begin
                            t_active_reg[slot_reg] <= 1'b1;
                            t_owner_reg[slot_reg]  <= tsk;
                            t_sig_reg[slot_reg]    <= sig_reg;
                            t_rem_reg[slot_reg]    <= amt_reg;
                            t_rel_reg[slot_reg]    <= amt_reg;
                            t_repeat_reg[slot_reg] <= (op_reg == OP_RSET);
                            done_reg               <= 1'b1;
                        end else if (slot_last) begin
                            status_reg <= ST_NO_TIMER;
                        end
                    end
                    OP_DELETE: begin
                        if (slot_match) begin
                            t_active_reg[slot_reg] <= 1'b0;
                            t_repeat_reg[slot_reg] <= 1'b0;
                            done_reg               <= 1'b1;
                        end else if (slot_last) begin
                            status_reg <= ST_NOT_FOUND;
                        end
                    end
                    default: ;
                endcase
            end
            // present result
            if (cmd.finish) begin
                res_status <= status_reg;
                res_task   <= 2'(otask_reg);
                res_signal <= ovalid_reg ? rd_data_reg : 8'd0;
                res_valid  <= ovalid_reg;
            end
        end
    end

endmodule
`default_nettype wire

### bench/event_queue_timer_scheduler_top_tb.sv
// Testbench for the event queue and timer scheduler top level.
// Depends on eqts_pkg and event_queue_timer_scheduler_top; predicts each result word.
`timescale 1ns / 1ps
module event_queue_timer_scheduler_top_tb;
    import eqts_pkg::*;

    // last member sits in the lowest bits, matching the tdata layout
    typedef struct packed {
        logic [15:0] amount;
        logic [7:0]  sig;
        logic [7:0]  task_id;
        logic [2:0]  op;
    } request_t;

    typedef struct packed {
        logic       event_valid;
        logic [7:0] out_signal;
        logic [1:0] out_task;
        logic [2:0] status;
    } result_t;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [2:0] OP_UNUSED6 = 3'd6;
    localparam logic [2:0] OP_UNUSED7 = 3'd7;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    request_t pending_requests[$];
    result_t  expected_results[$];
    int       mismatch_count = 0;
    int       cycle_count = 0;
    bit       burst_mode = 1'b0;
    int       holdoff_cycles;

    // predictor state
    logic [7:0]  fifo_mem[NUM_TASKS][QUEUE_DEPTH];
    int          fifo_head[NUM_TASKS];
    int          fifo_tail[NUM_TASKS];
    int          fifo_count[NUM_TASKS];
    bit          tmr_active[NUM_TIMERS];
    int          tmr_owner[NUM_TIMERS];
    logic [7:0]  tmr_sig[NUM_TIMERS];
    logic [15:0] tmr_left[NUM_TIMERS];
    logic [15:0] tmr_period[NUM_TIMERS];
    bit          tmr_periodic[NUM_TIMERS];

    event_queue_timer_scheduler_top u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic status_t fifo_push(int t, logic [7:0] s);
        if (fifo_count[t] >= QUEUE_DEPTH) return ST_FULL;
        fifo_mem[t][fifo_tail[t]] = s;
        fifo_tail[t] = (fifo_tail[t] + 1) % QUEUE_DEPTH;
        fifo_count[t]++;
        return ST_OK;
    endfunction

    // Advance the scheduler state by one request and return its result word.
    function automatic result_t schedule_request(request_t r);
        result_t res;
        int      t;
        res = '0;
        res.status = ST_OK;
        case (r.op)
            OP_POST: begin
                res.status = (r.task_id < NUM_TASKS) ? fifo_push(r.task_id, r.sig)
                                                     : ST_BAD_TASK;
            end
            OP_DISPATCH: begin
                for (t = 0; t < NUM_TASKS; t++) if (fifo_count[t] != 0) break;
                if (t < NUM_TASKS) begin
                    res.out_signal = fifo_mem[t][fifo_head[t]];
                    fifo_head[t] = (fifo_head[t] + 1) % QUEUE_DEPTH;
                    fifo_count[t]--;
                    res.out_task = t[1:0];
                    res.event_valid = 1'b1;
                end else begin
                    res.status = ST_IDLE;
                end
            end
            OP_TICK: begin
                if (r.amount != 0) begin
                    for (int i = 0; i < NUM_TIMERS; i++) begin
                        if (!tmr_active[i]) continue;
                        if (tmr_left[i] > r.amount) begin
                            tmr_left[i] = tmr_left[i] - r.amount;
                        end else begin
                            void'(fifo_push(tmr_owner[i], tmr_sig[i]));
                            if (tmr_periodic[i]) tmr_left[i] = tmr_period[i];
                            else tmr_active[i] = 1'b0;
                        end
                    end
                end
            end
            OP_SET, OP_RSET: begin
                if (r.task_id >= NUM_TASKS) begin
                    res.status = ST_BAD_TASK;
                end else begin
                    res.status = ST_NO_TIMER;
                    for (int i = 0; i < NUM_TIMERS; i++) begin
                        if (tmr_active[i] && tmr_owner[i] == r.task_id
                                && tmr_sig[i] == r.sig) begin
                            res.status = ST_EXISTS;
                            break;
                        end
                        if (!tmr_active[i]) begin
                            tmr_active[i]   = 1'b1;
                            tmr_owner[i]    = r.task_id;
                            tmr_sig[i]      = r.sig;
                            tmr_left[i]     = r.amount;
                            tmr_period[i]   = r.amount;
                            tmr_periodic[i] = (r.op == OP_RSET);
                            res.status = ST_OK;
                            break;
                        end
                    end
                end
            end
            OP_DELETE: begin
                if (r.task_id >= NUM_TASKS) begin
                    res.status = ST_BAD_TASK;
                end else begin
                    res.status = ST_NOT_FOUND;
                    for (int i = 0; i < NUM_TIMERS; i++) begin
                        if (tmr_active[i] && tmr_owner[i] == r.task_id
                                && tmr_sig[i] == r.sig) begin
                            tmr_active[i]   = 1'b0;
                            tmr_periodic[i] = 1'b0;
                            res.status = ST_OK;
                            break;
                        end
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic request_t make_request(logic [2:0] op, logic [7:0] tid,
                                              logic [7:0] s, logic [15:0] amt);
        request_t r;
        r.op = op; r.task_id = tid; r.sig = s; r.amount = amt;
        return r;
    endfunction

    // Pick a random request; mostly valid tasks and short timeouts.
    function automatic request_t random_request();
        request_t   r;
        int         sel;
        logic [2:0] ops[6];
        ops = '{OP_POST, OP_DISPATCH, OP_TICK, OP_SET, OP_RSET, OP_DELETE};
        sel = $urandom_range(0, 99);
        if (sel < 3) r.op = 3'($urandom_range(0, 7));
        else r.op = ops[$urandom_range(0, 5)];
        r.task_id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        // few distinct signals so set, delete and exists hit often
        r.sig = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
        case ($urandom_range(0, 9))
            0: r.amount = 16'($urandom);
            1: r.amount = 16'hFFFF;
            2: r.amount = 16'd0;
            default: r.amount = 16'($urandom_range(1, 40));
        endcase
        return r;
    endfunction

    // Fill the stimulus queue: directed corner cases, then random traffic.
    initial begin
        for (int t = 0; t < NUM_TASKS; t++) begin
            fifo_head[t] = 0; fifo_tail[t] = 0; fifo_count[t] = 0;
        end
        for (int i = 0; i < NUM_TIMERS; i++) begin
            tmr_active[i] = 1'b0; tmr_periodic[i] = 1'b0;
        end
        pending_requests.push_back(make_request(OP_DISPATCH, 8'd0, 8'd0, 16'd0));
        pending_requests.push_back(make_request(OP_POST, 8'd255, 8'hFF, 16'hFFFF));
        pending_requests.push_back(make_request(OP_POST, 8'd3, 8'hFF, 16'd0));
        for (int k = 0; k < 8; k++)
            pending_requests.push_back(make_request(OP_POST, 8'd1, 8'(k), 16'd0));
        pending_requests.push_back(make_request(OP_SET, 8'd0, 8'h00, 16'd5));
        pending_requests.push_back(make_request(OP_SET, 8'd0, 8'h00, 16'd9));
        pending_requests.push_back(make_request(OP_RSET, 8'd2, 8'hAA, 16'd0));
        pending_requests.push_back(make_request(OP_RSET, 8'd4, 8'h01, 16'd1));
        pending_requests.push_back(make_request(OP_TICK, 8'd0, 8'd0, 16'd0));
        pending_requests.push_back(make_request(OP_TICK, 8'hFF, 8'hFF, 16'd5));
        pending_requests.push_back(make_request(OP_DELETE, 8'd2, 8'hAA, 16'd0));
        pending_requests.push_back(make_request(OP_DELETE, 8'd2, 8'hAA, 16'd0));
        pending_requests.push_back(make_request(OP_DELETE, 8'd9, 8'hAA, 16'd0));
        pending_requests.push_back(make_request(OP_UNUSED6, 8'd1, 8'd1, 16'd1));
        pending_requests.push_back(make_request(OP_UNUSED7, 8'd1, 8'd1, 16'd1));
        for (int k = 0; k < 8; k++)
            pending_requests.push_back(make_request(OP_SET, 8'(k % 4), 8'(k + 16),
                                                    16'hFFFF));
        pending_requests.push_back(make_request(OP_SET, 8'd0, 8'h77, 16'd3));
        for (int k = 0; k < 1750; k++) pending_requests.push_back(random_request());
    end

    // Drive request words; idle at random except in burst stretches.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_requests.size() > 0 &&
                    (burst_mode || $urandom_range(0, 99) >= 33)) begin
                request_t r;
                r = pending_requests.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {5'd0, r.amount, r.sig, r.task_id, r.op};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Predict at accept time.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            expected_results.push_back(schedule_request(request_t'(s_tdata[34:0])));
    end

    // Receiver readiness: random stalls, one long hold-off, burst stretch.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            holdoff_cycles <= 0;
        end else if (cycle_count == 3000) begin
            m_tready <= 1'b0;
            holdoff_cycles <= 300;
        end else if (holdoff_cycles > 0) begin
            holdoff_cycles <= holdoff_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= burst_mode || ($urandom_range(0, 99) >= 33);
        end
    end

    // Check result words against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            result_t got, want;
            got = result_t'(m_tdata[13:0]);
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result word %h", m_tdata);
            end else begin
                want = expected_results.pop_front();
                if (got !== want || m_tdata[15:14] !== 2'b00) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp st=%0d task=%0d sig=%h ev=%b, got st=%0d task=%0d sig=%h ev=%b",
                                 want.status, want.out_task, want.out_signal, want.event_valid,
                                 got.status, got.out_task, got.out_signal, got.event_valid);
                end
            end
        end
    end

    // Cycle count, burst window and timeout.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        burst_mode  <= (cycle_count >= 6000 && cycle_count < 8000);
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_requests.size() == 0 && !s_tvalid);
        wait (expected_results.size() == 0);
        repeat (50) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

### filelist.f
rtl/core/eqts_pkg.sv
rtl/core/eqts_ctrl.sv
rtl/core/eqts_datapath.sv
rtl/core/event_queue_timer_scheduler_top.sv
bench/event_queue_timer_scheduler_top_tb.sv
